// ----- rtl/core/lc3x_pkg.sv -----
// Shared types, constants and helper functions of the LC-3 subset executor.
package lc3x_pkg;

    localparam int unsigned LC3X_MEM_WORDS = 65536;
    localparam int unsigned WORD_W         = 16;
    localparam logic [15:0] START_PC_RST   = 16'h3000;

    localparam logic [2:0] FLAG_P = 3'b001;
    localparam logic [2:0] FLAG_Z = 3'b010;
    localparam logic [2:0] FLAG_N = 3'b100;

    localparam logic [3:0] OPC_ADD = 4'd1;
    localparam logic [3:0] OPC_LD  = 4'd2;
    localparam logic [3:0] OPC_ST  = 4'd3;
    localparam logic [3:0] OPC_AND = 4'd5;
    localparam logic [3:0] OPC_RTI = 4'd8;
    localparam logic [3:0] OPC_LDI = 4'd10;
    localparam logic [3:0] OPC_RES = 4'd13;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_EXEC,
        S_MEM1,
        S_MEM2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic cfg_load;
        logic load_write;
        logic fetch;
        logic decode;
        logic rd_ind;
        logic st_write;
        logic wb_alu;
        logic wb_mem;
        logic halt;
    } t_cmd;

    typedef struct packed {
        logic       op;
        logic       stopped;
        logic [3:0] opcode;
    } t_stat;

    function automatic logic [15:0] sext9(input logic [15:0] w);
        sext9 = {{7{w[8]}}, w[8:0]};
    endfunction

    function automatic logic [15:0] sext5(input logic [15:0] w);
        sext5 = {{11{w[4]}}, w[4:0]};
    endfunction

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        if (v == 16'd0) begin
            flags_of = FLAG_Z;
        end else if (v[15]) begin
            flags_of = FLAG_N;
        end else begin
            flags_of = FLAG_P;
        end
    endfunction

endpackage

// ----- rtl/core/lc3x_ctrl.sv -----
// Controller state machine: sequences load, fetch, decode, execute and memory reads.
module lc3x_ctrl import lc3x_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_cfg_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done,
    output logic  o_cfg_ready
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_busy      = 1'b1;
        o_done      = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cfg_ready  = 1'b1;
                o_cmd.cfg_load = i_cfg_valid;
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (!i_stat.op) begin
                        o_cmd.load_write = 1'b1;
                        n_state = S_DONE;
                    end else if (i_stat.stopped) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_stat.opcode == OPC_LD || i_stat.opcode == OPC_LDI) begin
                    n_state = S_MEM1;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_stat.opcode)
                    OPC_ADD, OPC_AND: o_cmd.wb_alu   = 1'b1;
                    OPC_ST:           o_cmd.st_write = 1'b1;
                    OPC_RTI, OPC_RES: o_cmd.halt     = 1'b1;
                    default: ;
                endcase
            end
            S_MEM1: begin
                if (i_stat.opcode == OPC_LDI) begin
                    o_cmd.rd_ind = 1'b1;
                    n_state = S_MEM2;
                end else begin
                    o_cmd.wb_mem = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_MEM2: begin
                o_cmd.wb_mem = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/lc3x_dpath.sv -----
// Datapath: main memory, register file, program counter, flags and result registers.
module lc3x_dpath import lc3x_pkg::*; #(
    parameter int unsigned MEM_WORDS = LC3X_MEM_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_op,
    input  logic [15:0] i_load_addr,
    input  logic [15:0] i_load_data,
    input  logic [15:0] i_cfg_data,
    output logic [15:0] o_pc_after,
    output logic [15:0] o_fetched_instr,
    output logic        o_reg_written,
    output logic [2:0]  o_dest_index,
    output logic [15:0] o_dest_value,
    output logic [2:0]  o_cond_flags,
    output logic        o_store_done,
    output logic [15:0] o_store_addr,
    output logic [15:0] o_store_data,
    output logic        o_halted
);

    localparam int unsigned AW = $clog2(MEM_WORDS);

    logic [15:0] r_mem [MEM_WORDS];
    logic [15:0] r_rdata;
    logic [15:0] r_rf [8];
    logic [15:0] r_pc;
    logic [15:0] r_instr;
    logic [15:0] r_opa;
    logic [15:0] r_opb;
    logic [2:0]  r_cc;
    logic        r_stopped;
    logic        r_wrote;
    logic [2:0]  r_dr;
    logic [15:0] r_dval;
    logic        r_stored;
    logic [15:0] r_saddr;
    logic [15:0] r_sdata;

    logic [15:0] w;
    logic [15:0] ea;
    logic [15:0] mem_addr;
    logic [15:0] mem_wdata;
    logic        mem_we;
    logic [2:0]  rb_idx;
    logic [15:0] alu_b;
    logic [15:0] alu_y;
    logic [15:0] wb_val;
    logic        wb_en;

    assign w  = i_cmd.decode ? r_rdata : r_instr;
    assign ea = r_pc + sext9(w);

    always_comb begin
        if (i_cmd.load_write) begin
            mem_addr = i_load_addr;
        end else if (i_cmd.fetch) begin
            mem_addr = r_pc;
        end else if (i_cmd.rd_ind) begin
            mem_addr = r_rdata;
        end else begin
            mem_addr = ea;
        end
    end

    assign mem_we    = i_cmd.load_write | i_cmd.st_write;
    assign mem_wdata = i_cmd.load_write ? i_load_data : r_opb;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr[AW-1:0]] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr[AW-1:0]];
    end

    assign rb_idx = (w[15:12] == OPC_ST) ? w[11:9] : w[2:0];
    assign alu_b  = r_instr[5] ? sext5(r_instr) : r_opb;
    assign alu_y  = (r_instr[15:12] == OPC_AND) ? (r_opa & alu_b) : (r_opa + alu_b);
    assign wb_val = i_cmd.wb_alu ? alu_y : r_rdata;
    assign wb_en  = i_cmd.wb_alu | i_cmd.wb_mem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_rf[i] <= '0;
            end
            r_pc      <= START_PC_RST;
            r_cc      <= FLAG_Z;
            r_stopped <= 1'b0;
        end else begin
            if (wb_en) begin
                r_rf[r_instr[11:9]] <= wb_val;
                r_cc                <= flags_of(wb_val);
            end
            if (i_cmd.cfg_load) begin
                r_pc <= i_cfg_data;
            end else if (i_cmd.fetch) begin
                r_pc <= r_pc + 16'd1;
            end
            if (i_cmd.halt) begin
                r_stopped <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_opa <= r_rf[w[8:6]];
            r_opb <= r_rf[rb_idx];
        end
        if (i_cmd.accept) begin
            r_instr  <= '0;
            r_wrote  <= 1'b0;
            r_dr     <= '0;
            r_dval   <= '0;
            r_stored <= 1'b0;
            r_saddr  <= '0;
            r_sdata  <= '0;
        end else begin
            if (i_cmd.decode) begin
                r_instr <= r_rdata;
            end
            if (wb_en) begin
                r_wrote <= 1'b1;
                r_dr    <= r_instr[11:9];
                r_dval  <= wb_val;
            end
            if (i_cmd.st_write) begin
                r_stored <= 1'b1;
                r_saddr  <= ea;
                r_sdata  <= r_opb;
            end
        end
    end

    assign o_stat.op      = i_op;
    assign o_stat.stopped = r_stopped;
    assign o_stat.opcode  = w[15:12];

    assign o_pc_after      = r_pc;
    assign o_fetched_instr = r_instr;
    assign o_reg_written   = r_wrote;
    assign o_dest_index    = r_dr;
    assign o_dest_value    = r_dval;
    assign o_cond_flags    = r_cc;
    assign o_store_done    = r_stored;
    assign o_store_addr    = r_saddr;
    assign o_store_data    = r_sdata;
    assign o_halted        = r_stopped;

endmodule

// ----- rtl/core/lc3_subset_instruction_executor_unit.sv -----
// Top level of the LC-3 subset executor: controller plus datapath.
// Usage:
//   Command channel: an item transfers on a rising edge with i_start high and o_busy
//   low. i_op = 0 writes i_load_data to memory word i_load_addr; i_op = 1 executes
//   the instruction at the program counter.
//   Result channel: o_done is high for exactly one cycle with all result ports valid;
//   the receiver cannot stall it, so results must be taken on that cycle.
//   Config channel: i_cfg_valid / o_cfg_ready transfer start_pc, which loads the
//   program counter at once. o_cfg_ready is high only while idle.
// Sequence: a memory write or a step while halted goes straight to done; ADD, AND,
//   ST, halt and no-op opcodes pass fetch, decode and execute; LD and LDI pass
//   fetch, decode and one or two memory states. The next command transfers the
//   cycle after o_done. The sequence is set by the single synchronous memory port:
//   fetch, then one or two dependent data reads for LD and LDI.
// Reset (synchronous, active low): program counter 0x3000, registers zero, flags Z,
//   machine running. Memory content is undefined until written.
module lc3_subset_instruction_executor_unit import lc3x_pkg::*; #(
    parameter int unsigned MEM_WORDS = LC3X_MEM_WORDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_op,
    input  logic [15:0] i_load_addr,
    input  logic [15:0] i_load_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic [15:0] o_pc_after,
    output logic [15:0] o_fetched_instr,
    output logic        o_reg_written,
    output logic [2:0]  o_dest_index,
    output logic [15:0] o_dest_value,
    output logic [2:0]  o_cond_flags,
    output logic        o_store_done,
    output logic [15:0] o_store_addr,
    output logic [15:0] o_store_data,
    output logic        o_halted
);

    t_cmd  cmd;
    t_stat stat;

    lc3x_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cfg_valid (i_cfg_valid),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_cfg_ready (o_cfg_ready)
    );

    lc3x_dpath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_op            (i_op),
        .i_load_addr     (i_load_addr),
        .i_load_data     (i_load_data),
        .i_cfg_data      (i_cfg_data),
        .o_pc_after      (o_pc_after),
        .o_fetched_instr (o_fetched_instr),
        .o_reg_written   (o_reg_written),
        .o_dest_index    (o_dest_index),
        .o_dest_value    (o_dest_value),
        .o_cond_flags    (o_cond_flags),
        .o_store_done    (o_store_done),
        .o_store_addr    (o_store_addr),
        .o_store_data    (o_store_data),
        .o_halted        (o_halted)
    );

endmodule
